[src/ptom_pkg.sv]
package ptom_pkg;

   localparam logic [31:0] FILL_SEQ_START = 32'd1000;

   typedef enum logic [2:0] {
      MODE_LIMIT  = 3'd0,
      MODE_MARKET = 3'd1,
      MODE_CANCEL = 3'd2,
      MODE_MODIFY = 3'd3
   } mode_type;

   typedef enum logic [2:0] {
      REASON_NONE      = 3'd0,
      REASON_BAD_TYPE  = 3'd1,
      REASON_UNKNOWN   = 3'd2,
      REASON_NO_LIQ    = 3'd3,
      REASON_BOOK_FULL = 3'd4
   } reason_type;

   typedef struct packed {
      logic        last;
      logic [31:0] echo_request;
      logic [31:0] aggressor_id;
      logic [31:0] resting_id;
      logic        aggressor_buys;
      logic [31:0] fill_price;
      logic [31:0] fill_qty;
      logic [31:0] fill_seq;
      logic        status;
      logic [2:0]  reason;
      logic [31:0] filled_total;
      logic [31:0] leaves_qty;
   } result_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] price;
      logic [31:0] qty;
   } entry_type;

endpackage

[src/ptom_side_mem.sv]
module ptom_side_mem
   import ptom_pkg::*;
#(
   parameter int Depth = 32,
   parameter int AddrWidth = 5
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  entry_type            wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output entry_type            rd_data
);
   entry_type mem [Depth];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[src/price_time_order_matcher_core.sv]
// Price-time priority limit order book. Each side keeps up to SIDE_DEPTH
// resting orders in a registered-read memory, best price first and by arrival
// within a price. One request is handled at a time by a sequencer that reads
// or moves one entry at a time, and req_stall stays high from the accepting
// edge until the outcome has been loaded into the output register.
// A lookup walks the bid side then the ask side entry by entry, a removal
// shifts the entries behind the removed one, a fill reads the opposite head
// and removes it once exhausted, and an insertion searches for its place
// and then shifts the entries behind it. An invalid mode or a market order
// against an empty side goes straight to the outcome, and a modify looks
// the order up, removes it and then matches and re-inserts it.
// A fill or the outcome waits while the output register still holds a result
// that has not been transferred; the outcome transfer carries rsp_last.
module price_time_order_matcher_core
   import ptom_pkg::*;
#(
   parameter int SIDE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_request_id,
   input  logic [31:0] req_order_id,
   input  logic        req_side,
   input  logic [31:0] req_price,
   input  logic [31:0] req_quantity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_last,
   output logic [31:0] rsp_echo_request,
   output logic [31:0] rsp_aggressor_id,
   output logic [31:0] rsp_resting_id,
   output logic        rsp_aggressor_buys,
   output logic [31:0] rsp_fill_price,
   output logic [31:0] rsp_fill_qty,
   output logic [31:0] rsp_fill_seq,
   output logic        rsp_status,
   output logic [2:0]  rsp_reason,
   output logic [31:0] rsp_filled_total,
   output logic [31:0] rsp_leaves_qty
);
   localparam int AW = (SIDE_DEPTH > 1) ? $clog2(SIDE_DEPTH) : 1;
   localparam int CW = $clog2(SIDE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(SIDE_DEPTH);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'h0001,
      ST_DISP    = 13'h0002,
      ST_FRD     = 13'h0004,
      ST_FCHK    = 13'h0008,
      ST_RMRD    = 13'h0010,
      ST_RMWR    = 13'h0020,
      ST_MHEAD   = 13'h0040,
      ST_MCHK    = 13'h0080,
      ST_IFIND   = 13'h0100,
      ST_ICHK    = 13'h0200,
      ST_ISHIFT  = 13'h0400,
      ST_IWR     = 13'h0800,
      ST_OUT     = 13'h1000
   } state_type;

   // Next step after a removal completes.
   typedef enum logic [1:0] {
      AFT_MATCH  = 2'd0,
      AFT_CANCEL = 2'd1,
      AFT_MODIFY = 2'd2
   } after_type;

   state_type   state_ff, state_in;
   logic [2:0]  mode_ff;
   logic [31:0] rid_ff, oid_ff, px_ff, qty_ff, rem_ff;
   logic        side_ff, market_ff;
   logic [CW-1:0] bid_count_ff, ask_count_ff;
   logic [31:0] fill_counter_ff;
   logic        fside_ff;
   logic [CW-1:0] idx_ff;
   logic        rm_side_ff;
   after_type   after_ff;
   logic        ins_side_ff;
   logic [CW-1:0] pos_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   logic        res_status_ff;
   logic [2:0]  res_reason_ff;
   logic [31:0] res_total_ff, res_left_ff;

   logic        we_b, we_a;
   logic [AW-1:0] wa_b, wa_a, ra_b, ra_a;
   entry_type   wd_b, wd_a, rd_b, rd_a;

   ptom_side_mem #(.Depth(SIDE_DEPTH), .AddrWidth(AW)) u_bid (
      .clock(clock), .wr_en(we_b), .wr_addr(wa_b), .wr_data(wd_b),
      .rd_addr(ra_b), .rd_data(rd_b)
   );
   ptom_side_mem #(.Depth(SIDE_DEPTH), .AddrWidth(AW)) u_ask (
      .clock(clock), .wr_en(we_a), .wr_addr(wa_a), .wr_data(wd_a),
      .rd_addr(ra_a), .rd_data(rd_a)
   );

   logic        rd_side;
   logic [CW-1:0] rd_idx;
   logic        wr_en, wr_side;
   logic [CW-1:0] wr_idx;
   entry_type   wr_data;

   assign ra_b = rd_idx[AW-1:0];
   assign ra_a = rd_idx[AW-1:0];
   assign wa_b = wr_idx[AW-1:0];
   assign wa_a = wr_idx[AW-1:0];
   assign wd_b = wr_data;
   assign wd_a = wr_data;
   assign we_b = wr_en && !wr_side;
   assign we_a = wr_en && wr_side;

   logic rd_side_ff;

   logic [CW-1:0] cnt_rm, cnt_ins, cnt_opp;
   assign cnt_rm  = rm_side_ff ? ask_count_ff : bid_count_ff;
   assign cnt_ins = ins_side_ff ? ask_count_ff : bid_count_ff;
   assign cnt_opp = ins_side_ff ? bid_count_ff : ask_count_ff;
   entry_type rd_now;
   assign rd_now = rd_side_ff ? rd_a : rd_b;

   logic [31:0] fq;
   logic        can_trade;
   logic        ins_stop;
   assign fq = (rem_ff < rd_now.qty) ? rem_ff : rd_now.qty;
   assign can_trade = market_ff ||
                      (!ins_side_ff && !(px_ff < rd_now.price)) ||
                      (ins_side_ff && !(px_ff > rd_now.price));
   assign ins_stop = ins_side_ff ? (rd_now.price > px_ff) : (rd_now.price < px_ff);

   logic out_free;
   assign out_free = !out_valid_ff || !rsp_stall;

   logic [CW-1:0] bid_count_in, ask_count_in;
   logic [31:0] fill_counter_in, rem_in;
   logic        fside_in, rm_side_in, ins_side_in, market_in;
   logic [CW-1:0] idx_in, pos_in;
   after_type   after_in;
   logic        out_valid_in;
   result_type  out_in;
   logic        res_status_in;
   logic [2:0]  res_reason_in;
   logic [31:0] res_total_in, res_left_in;
   logic        accept;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      bid_count_in = bid_count_ff;
      ask_count_in = ask_count_ff;
      fill_counter_in = fill_counter_ff;
      rem_in = rem_ff;
      fside_in = fside_ff;
      rm_side_in = rm_side_ff;
      ins_side_in = ins_side_ff;
      market_in = market_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      after_in = after_ff;
      res_status_in = res_status_ff;
      res_reason_in = res_reason_ff;
      res_total_in = res_total_ff;
      res_left_in = res_left_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in = out_ff;
      rd_side = rd_side_ff;
      rd_idx = '0;
      wr_en = 1'b0;
      wr_side = 1'b0;
      wr_idx = '0;
      wr_data = rd_now;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            rem_in = qty_ff;
            ins_side_in = side_ff;
            market_in = (mode_ff == MODE_MARKET);
            res_status_in = 1'b0;
            res_reason_in = REASON_NONE;
            res_total_in = '0;
            res_left_in = '0;
            if (mode_ff == MODE_LIMIT) begin
               state_in = ST_MHEAD;
            end else if (mode_ff == MODE_MARKET) begin
               if ((side_ff ? bid_count_ff : ask_count_ff) == '0) begin
                  res_status_in = 1'b1;
                  res_reason_in = REASON_NO_LIQ;
                  res_left_in = qty_ff;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_MHEAD;
               end
            end else if (mode_ff == MODE_CANCEL || mode_ff == MODE_MODIFY) begin
               fside_in = 1'b0;
               idx_in = '0;
               state_in = ST_FRD;
            end else begin
               res_status_in = 1'b1;
               res_reason_in = REASON_BAD_TYPE;
               state_in = ST_OUT;
            end
         end
         ST_FRD: begin
            if (idx_ff >= (fside_ff ? ask_count_ff : bid_count_ff)) begin
               if (fside_ff) begin
                  res_status_in = 1'b1;
                  res_reason_in = REASON_UNKNOWN;
                  state_in = ST_OUT;
               end else begin
                  fside_in = 1'b1;
                  idx_in = '0;
               end
            end else begin
               rd_side = fside_ff;
               rd_idx = idx_ff;
               state_in = ST_FCHK;
            end
         end
         ST_FCHK: begin
            if (rd_now.id == oid_ff) begin
               rm_side_in = fside_ff;
               ins_side_in = fside_ff;
               after_in = (mode_ff == MODE_MODIFY) ? AFT_MODIFY : AFT_CANCEL;
               state_in = ST_RMRD;
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_FRD;
            end
         end
         ST_RMRD: begin
            if (idx_ff + CW'(1) < cnt_rm) begin
               rd_side = rm_side_ff;
               rd_idx = idx_ff + CW'(1);
               state_in = ST_RMWR;
            end else begin
               if (rm_side_ff) begin
                  ask_count_in = ask_count_ff - CW'(1);
               end else begin
                  bid_count_in = bid_count_ff - CW'(1);
               end
               unique case (after_ff)
                  AFT_CANCEL: state_in = ST_OUT;
                  default: state_in = ST_MHEAD;
               endcase
            end
         end
         ST_RMWR: begin
            wr_en = 1'b1;
            wr_side = rm_side_ff;
            wr_idx = idx_ff;
            wr_data = rd_now;
            idx_in = idx_ff + CW'(1);
            state_in = ST_RMRD;
         end
         ST_MHEAD: begin
            if (cnt_opp != '0 && rem_ff != '0) begin
               if (out_free) begin
                  rd_side = !ins_side_ff;
                  rd_idx = '0;
                  state_in = ST_MCHK;
               end
            end else if (market_ff || rem_ff == '0) begin
               res_status_in = market_ff && (rem_ff != '0);
               res_reason_in = (market_ff && rem_ff != '0) ? REASON_NO_LIQ : REASON_NONE;
               res_total_in = qty_ff - rem_ff;
               res_left_in = rem_ff;
               state_in = ST_OUT;
            end else if (cnt_ins >= DEPTH_C) begin
               res_status_in = 1'b1;
               res_reason_in = REASON_BOOK_FULL;
               res_total_in = qty_ff - rem_ff;
               res_left_in = rem_ff;
               state_in = ST_OUT;
            end else begin
               pos_in = '0;
               state_in = ST_IFIND;
            end
         end
         ST_MCHK: begin
            if (!can_trade) begin
               if (cnt_ins >= DEPTH_C) begin
                  res_status_in = 1'b1;
                  res_reason_in = REASON_BOOK_FULL;
                  res_total_in = qty_ff - rem_ff;
                  res_left_in = rem_ff;
                  state_in = ST_OUT;
               end else begin
                  pos_in = '0;
                  state_in = ST_IFIND;
               end
            end else begin
               fill_counter_in = fill_counter_ff + 32'd1;
               out_valid_in = 1'b1;
               out_in = '0;
               out_in.echo_request = rid_ff;
               out_in.aggressor_id = oid_ff;
               out_in.resting_id = rd_now.id;
               out_in.aggressor_buys = !ins_side_ff;
               out_in.fill_price = rd_now.price;
               out_in.fill_qty = fq;
               out_in.fill_seq = fill_counter_ff + 32'd1;
               rem_in = rem_ff - fq;
               if (rd_now.qty == fq) begin
                  rm_side_in = !ins_side_ff;
                  idx_in = '0;
                  after_in = AFT_MATCH;
                  state_in = ST_RMRD;
               end else begin
                  wr_en = 1'b1;
                  wr_side = !ins_side_ff;
                  wr_idx = '0;
                  wr_data = rd_now;
                  wr_data.qty = rd_now.qty - fq;
                  state_in = ST_MHEAD;
               end
            end
         end
         ST_IFIND: begin
            if (pos_ff >= cnt_ins) begin
               idx_in = cnt_ins;
               state_in = ST_ISHIFT;
            end else begin
               rd_side = ins_side_ff;
               rd_idx = pos_ff;
               state_in = ST_ICHK;
            end
         end
         ST_ICHK: begin
            if (ins_stop) begin
               idx_in = cnt_ins;
               state_in = ST_ISHIFT;
            end else begin
               pos_in = pos_ff + CW'(1);
               state_in = ST_IFIND;
            end
         end
         ST_ISHIFT: begin
            if (idx_ff == pos_ff) begin
               wr_en = 1'b1;
               wr_side = ins_side_ff;
               wr_idx = pos_ff;
               wr_data.id = oid_ff;
               wr_data.price = px_ff;
               wr_data.qty = rem_ff;
               if (ins_side_ff) begin
                  ask_count_in = ask_count_ff + CW'(1);
               end else begin
                  bid_count_in = bid_count_ff + CW'(1);
               end
               res_status_in = 1'b0;
               res_reason_in = REASON_NONE;
               res_total_in = qty_ff - rem_ff;
               res_left_in = rem_ff;
               state_in = ST_OUT;
            end else begin
               rd_side = ins_side_ff;
               rd_idx = idx_ff - CW'(1);
               state_in = ST_IWR;
            end
         end
         ST_IWR: begin
            wr_en = 1'b1;
            wr_side = ins_side_ff;
            wr_idx = idx_ff;
            wr_data = rd_now;
            idx_in = idx_ff - CW'(1);
            state_in = ST_ISHIFT;
         end
         ST_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = '0;
               out_in.last = 1'b1;
               out_in.echo_request = rid_ff;
               out_in.status = res_status_ff;
               out_in.reason = res_reason_ff;
               out_in.filled_total = res_total_ff;
               out_in.leaves_qty = res_left_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bid_count_ff <= '0;
         ask_count_ff <= '0;
         fill_counter_ff <= FILL_SEQ_START;
         out_valid_ff <= 1'b0;
         rd_side_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bid_count_ff <= bid_count_in;
         ask_count_ff <= ask_count_in;
         fill_counter_ff <= fill_counter_in;
         out_valid_ff <= out_valid_in;
         rd_side_ff <= rd_side;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         rid_ff <= req_request_id;
         oid_ff <= req_order_id;
         side_ff <= req_side;
         px_ff <= req_price;
         qty_ff <= req_quantity;
      end
      rem_ff <= rem_in;
      fside_ff <= fside_in;
      rm_side_ff <= rm_side_in;
      ins_side_ff <= ins_side_in;
      market_ff <= market_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      after_ff <= after_in;
      res_status_ff <= res_status_in;
      res_reason_ff <= res_reason_in;
      res_total_ff <= res_total_in;
      res_left_ff <= res_left_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_last = out_ff.last;
   assign rsp_echo_request = out_ff.echo_request;
   assign rsp_aggressor_id = out_ff.aggressor_id;
   assign rsp_resting_id = out_ff.resting_id;
   assign rsp_aggressor_buys = out_ff.aggressor_buys;
   assign rsp_fill_price = out_ff.fill_price;
   assign rsp_fill_qty = out_ff.fill_qty;
   assign rsp_fill_seq = out_ff.fill_seq;
   assign rsp_status = out_ff.status;
   assign rsp_reason = out_ff.reason;
   assign rsp_filled_total = out_ff.filled_total;
   assign rsp_leaves_qty = out_ff.leaves_qty;

   assert property (@(posedge clock) disable iff (reset)
      bid_count_ff <= DEPTH_C && ask_count_ff <= DEPTH_C)
      else $error("side count above depth");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(out_ff))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DISP)
      else $error("accepted request not dispatched");
endmodule

[tb/tb.sv]
module tb;
   import ptom_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 32;
   localparam int CYCLE_LIMIT = 2000000;

   class book_scoreboard;
      logic [31:0] ids[2][DEPTH];
      logic [31:0] prices[2][DEPTH];
      logic [31:0] qtys[2][DEPTH];
      int count[2];
      logic [31:0] seq;
      result_type pending[$];
      int errors;

      function void clear();
         count[0] = 0;
         count[1] = 0;
         seq = FILL_SEQ_START;
         pending.delete();
         errors = 0;
      endfunction

      function void drop_entry(int s, int i);
         for (int j = i; j + 1 < count[s]; j++) begin
            ids[s][j] = ids[s][j + 1];
            prices[s][j] = prices[s][j + 1];
            qtys[s][j] = qtys[s][j + 1];
         end
         count[s]--;
      endfunction

      function void push_outcome(logic [31:0] rid, logic st, reason_type rs,
                                 logic [31:0] tot, logic [31:0] rem);
         result_type r;
         r = '0;
         r.last = 1'b1;
         r.echo_request = rid;
         r.status = st;
         r.reason = rs;
         r.filled_total = tot;
         r.leaves_qty = rem;
         pending.push_back(r);
      endfunction

      function logic [31:0] trade(int s, logic [31:0] oid, logic [31:0] px,
                                  logic [31:0] qty, bit any_price, logic [31:0] rid);
         int o;
         int nfill;
         logic [31:0] rem;
         logic [31:0] q;
         result_type r;
         o = 1 - s;
         nfill = 0;
         rem = qty;
         while (count[o] > 0 && rem > 0 && nfill < DEPTH) begin
            if (!any_price && s == 0 && px < prices[o][0]) break;
            if (!any_price && s == 1 && px > prices[o][0]) break;
            q = (rem < qtys[o][0]) ? rem : qtys[o][0];
            seq = seq + 32'd1;
            r = '0;
            r.echo_request = rid;
            r.aggressor_id = oid;
            r.resting_id = ids[o][0];
            r.aggressor_buys = (s == 0);
            r.fill_price = prices[o][0];
            r.fill_qty = q;
            r.fill_seq = seq;
            pending.push_back(r);
            nfill++;
            rem -= q;
            qtys[o][0] -= q;
            if (qtys[o][0] == 0) drop_entry(o, 0);
         end
         return rem;
      endfunction

      function void place_limit(int s, logic [31:0] oid, logic [31:0] px,
                                logic [31:0] qty, logic [31:0] rid);
         logic [31:0] rem;
         int pos;
         rem = trade(s, oid, px, qty, 1'b0, rid);
         if (rem > 0) begin
            if (count[s] >= DEPTH) begin
               push_outcome(rid, 1'b1, REASON_BOOK_FULL, qty - rem, rem);
               return;
            end
            pos = 0;
            while (pos < count[s]) begin
               if (s == 0 ? (prices[s][pos] < px) : (prices[s][pos] > px)) break;
               pos++;
            end
            for (int j = count[s]; j > pos; j--) begin
               ids[s][j] = ids[s][j - 1];
               prices[s][j] = prices[s][j - 1];
               qtys[s][j] = qtys[s][j - 1];
            end
            ids[s][pos] = oid;
            prices[s][pos] = px;
            qtys[s][pos] = rem;
            count[s]++;
         end
         push_outcome(rid, 1'b0, REASON_NONE, qty - rem, rem);
      endfunction

      function void note_request(logic [2:0] mode, logic [31:0] rid, logic [31:0] oid,
                                 logic side, logic [31:0] px, logic [31:0] qty);
         logic [31:0] rem;
         int fs;
         int fi;
         if (mode == MODE_LIMIT) begin
            place_limit(side, oid, px, qty, rid);
         end else if (mode == MODE_MARKET) begin
            if (count[1 - side] == 0) begin
               push_outcome(rid, 1'b1, REASON_NO_LIQ, 0, qty);
            end else begin
               rem = trade(side, oid, px, qty, 1'b1, rid);
               push_outcome(rid, rem != 0, rem != 0 ? REASON_NO_LIQ : REASON_NONE,
                            qty - rem, rem);
            end
         end else if (mode == MODE_CANCEL || mode == MODE_MODIFY) begin
            fs = -1;
            for (int k = 0; k < 2 && fs < 0; k++) begin
               for (int i = 0; i < count[k]; i++) begin
                  if (ids[k][i] == oid) begin
                     fs = k;
                     fi = i;
                     break;
                  end
               end
            end
            if (fs < 0) begin
               push_outcome(rid, 1'b1, REASON_UNKNOWN, 0, 0);
            end else begin
               drop_entry(fs, fi);
               if (mode == MODE_MODIFY) place_limit(fs, oid, px, qty, rid);
               else push_outcome(rid, 1'b0, REASON_NONE, 0, 0);
            end
         end else begin
            push_outcome(rid, 1'b1, REASON_BAD_TYPE, 0, 0);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $realtime, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p",
                     $realtime, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_mode;
   logic [31:0] req_request_id;
   logic [31:0] req_order_id;
   logic req_side;
   logic [31:0] req_price;
   logic [31:0] req_quantity;
   logic rsp_valid;
   logic rsp_stall;
   result_type rsp;

   book_scoreboard board;
   int cycles;
   logic [31:0] next_rid;
   logic [31:0] next_oid;
   logic [31:0] live_ids[$];
   bit calm;

   price_time_order_matcher_core #(.SIDE_DEPTH(DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_request_id(req_request_id), .req_order_id(req_order_id),
      .req_side(req_side), .req_price(req_price), .req_quantity(req_quantity),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_last(rsp.last),
      .rsp_echo_request(rsp.echo_request), .rsp_aggressor_id(rsp.aggressor_id),
      .rsp_resting_id(rsp.resting_id), .rsp_aggressor_buys(rsp.aggressor_buys),
      .rsp_fill_price(rsp.fill_price), .rsp_fill_qty(rsp.fill_qty),
      .rsp_fill_seq(rsp.fill_seq), .rsp_status(rsp.status), .rsp_reason(rsp.reason),
      .rsp_filled_total(rsp.filled_total), .rsp_leaves_qty(rsp.leaves_qty)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp);
      rsp_stall <= reset ? 1'b0 : (!calm && $urandom_range(99) < 37);
   end

   task automatic send(logic [2:0] mode, logic [31:0] oid, logic side,
                       logic [31:0] px, logic [31:0] qty);
      while (!calm && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_request_id <= next_rid;
      req_order_id <= oid;
      req_side <= side;
      req_price <= px;
      req_quantity <= qty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(mode, next_rid, oid, side, px, qty);
      next_rid = next_rid * 32'd1103515245 + 32'd12345;
   endtask

   task automatic submit_order(logic [2:0] mode, logic side, logic [31:0] px,
                               logic [31:0] qty);
      next_oid = next_oid + 32'd1;
      live_ids.push_back(next_oid);
      send(mode, next_oid, side, px, qty);
   endtask

   function automatic logic [31:0] pick_id();
      if (live_ids.size() == 0 || $urandom_range(9) == 0) return $urandom;
      return live_ids[$urandom_range(live_ids.size() - 1)];
   endfunction

   function automatic logic [31:0] pick_qty();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF - $urandom_range(3);
         2: return $urandom;
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   function automatic logic [31:0] pick_price();
      case ($urandom_range(19))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return 32'd100 + $urandom_range(10);
      endcase
   endfunction

   initial begin
      int roll;
      board = new();
      board.clear();
      cycles = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_LIMIT;
      req_request_id = '0;
      req_order_id = '0;
      req_side = 1'b0;
      req_price = '0;
      req_quantity = '0;
      rsp_stall = 1'b0;
      next_rid = 32'hA5A5_0001;
      next_oid = 32'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(MODE_MARKET, 32'd7, 1'b0, 32'd5, 32'd10);
      send(MODE_CANCEL, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0);
      send(MODE_MODIFY, 32'd0, 1'b1, 32'd1, 32'd1);
      for (int m = 4; m < 8; m++) send(m[2:0], 32'd3, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      submit_order(MODE_LIMIT, 1'b1, 32'd105, 32'd10);
      submit_order(MODE_LIMIT, 1'b1, 32'd105, 32'd20);
      submit_order(MODE_LIMIT, 1'b1, 32'd103, 32'd5);
      submit_order(MODE_LIMIT, 1'b0, 32'd0, 32'd0);
      submit_order(MODE_LIMIT, 1'b0, 32'd104, 32'd3);
      submit_order(MODE_LIMIT, 1'b0, 32'd105, 32'd12);
      submit_order(MODE_MARKET, 1'b0, 32'd0, 32'd100);
      send(MODE_LIMIT, 32'd900, 1'b0, 32'd50, 32'd4);
      send(MODE_LIMIT, 32'd900, 1'b0, 32'd51, 32'd4);
      send(MODE_MODIFY, 32'd900, 1'b0, 32'd52, 32'd0);
      send(MODE_CANCEL, 32'd900, 1'b0, 32'd0, 32'd0);
      submit_order(MODE_LIMIT, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      submit_order(MODE_MARKET, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 33; i++) send(MODE_LIMIT, 32'd500 + i, 1'b1, 32'd200, 32'd1);
      submit_order(MODE_MARKET, 1'b0, 32'd0, 32'd40);

      for (int n = 0; n < 56; n++) begin
         calm = (n >= 20 && n < 45);
         roll = $urandom_range(99);
         if (roll < 45) begin
            submit_order(MODE_LIMIT, 1'($urandom_range(1)), pick_price(), pick_qty());
         end else if (roll < 58) begin
            submit_order(MODE_MARKET, 1'($urandom_range(1)), $urandom, pick_qty());
         end else if (roll < 73) begin
            send(MODE_CANCEL, pick_id(), 1'($urandom_range(1)), $urandom, $urandom);
         end else if (roll < 90) begin
            send(MODE_MODIFY, pick_id(), 1'($urandom_range(1)), pick_price(), pick_qty());
         end else begin
            send(3'($urandom_range(4, 7)), $urandom, 1'($urandom_range(1)),
                 $urandom, $urandom);
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

[price_time_order_matcher_core.f]
src/ptom_pkg.sv
src/ptom_side_mem.sv
src/price_time_order_matcher_core.sv
tb/tb.sv
